// File: hw/rtl/kwm_pkg.sv
// Shared types and constants for the k-way run merger.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int VAL_W    = 32;  // element width
  localparam int IDX_W    = 4;   // run index width
  localparam int CNT_W    = 5;   // run count register width
  localparam int IDX_RUNS = 16;  // runs reachable by a run index

  // Input opcodes.
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_EXHAUST = 1'b1;

  // One classified input item as it travels from the front queue to the back end.
  typedef struct packed {
    logic             op;
    logic             active;
    logic [IDX_W-1:0] run;
    logic [VAL_W-1:0] value;
  } kwm_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/kwm_front.sv
// Front end of the k-way run merger: accepts input items, marks whether the
// run is active, and holds them in a two-entry queue. Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_front
  import kwm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    op_i,
  input  wire logic [IDX_W-1:0]        run_index_i,
  input  wire logic signed [VAL_W-1:0] element_value_i,
  input  wire logic [CNT_W-1:0]        n_eff_i,
  output logic                         item_valid_o,
  output kwm_item_t                    item_o,
  input  wire logic                    pop_i
);

  kwm_item_t  entry_q [2];
  kwm_item_t  new_item;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign busy         = (cnt_q == 2'd2);
  assign push         = start && !busy;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];

  always_comb begin
    new_item.op     = op_i;
    new_item.active = ({1'b0, run_index_i} < n_eff_i);
    new_item.run    = run_index_i;
    new_item.value  = element_value_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i && item_valid_o) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push, pop_i && item_valid_o})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/kwm_min_tree.sv
// Registered comparison tree that finds the smallest valid head, ties going
// to the lowest index. One tree level per cycle. Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_min_tree
  import kwm_pkg::*;
#(
  parameter int NR = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [NR-1:0]          leaf_valid_i,
  input  wire logic [NR*VAL_W-1:0]    leaf_value_i,
  output logic                        root_valid_o,
  output logic [VAL_W-1:0]            root_value_o,
  output logic [$clog2(NR)-1:0]       root_idx_o
);

  localparam int LG = $clog2(NR);
  localparam int P  = 1 << LG;

  // Heap layout: node i has children 2i and 2i+1; leaves sit at P..2P-1.
  logic             nv   [1:2*P-1];
  logic [VAL_W-1:0] nval [1:2*P-1];
  logic [LG-1:0]    nidx [1:2*P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < NR) begin : g_used
      assign nv[P+j]   = leaf_valid_i[j];
      assign nval[P+j] = leaf_value_i[j*VAL_W +: VAL_W];
      assign nidx[P+j] = LG'(j);
    end else begin : g_pad
      assign nv[P+j]   = 1'b0;
      assign nval[P+j] = '0;
      assign nidx[P+j] = '0;
    end
  end

  for (genvar i = 1; i < P; i++) begin : g_node
    logic take_r;

    // The right child wins only when strictly smaller, so ties keep the lower run.
    assign take_r = nv[2*i+1] &&
                    (!nv[2*i] || ($signed(nval[2*i+1]) < $signed(nval[2*i])));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv[i] <= 1'b0;
      end else begin
        nv[i] <= nv[2*i] || nv[2*i+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (take_r) begin
        nval[i] <= nval[2*i+1];
        nidx[i] <= nidx[2*i+1];
      end else begin
        nval[i] <= nval[2*i];
        nidx[i] <= nidx[2*i];
      end
    end
  end

  assign root_valid_o = nv[1];
  assign root_value_o = nval[1];
  assign root_idx_o   = nidx[1];

endmodule

`default_nettype wire

// File: hw/rtl/kwm_back.sv
// Back end of the k-way run merger: holds the run heads and status, applies
// queued items, runs the minimum search and drives results. Depends on kwm_pkg
// and kwm_min_tree.
`timescale 1ns / 1ps
`default_nettype none

module kwm_back
  import kwm_pkg::*;
#(
  parameter int NR = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [CNT_W-1:0] n_eff_i,
  input  wire logic         item_valid_i,
  input  wire kwm_item_t    item_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output logic [VAL_W-1:0]  res_value_o,
  output logic [IDX_W-1:0]  res_run_o,
  output logic              res_done_o
);

  localparam int LG = $clog2(NR);
  localparam int CW = $clog2(LG + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic              state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NR-1:0]     hv_q, hv_d;
  logic [NR-1:0]     fin_q, fin_d;
  logic              done_q, done_d;
  logic [VAL_W-1:0]  head_q [NR];
  logic [NR-1:0]     act;
  logic [NR*VAL_W-1:0] heads_flat;
  logic              ready_all;
  logic [LG-1:0]     widx;
  logic              wr_head;
  logic              root_valid;
  logic [VAL_W-1:0]  root_value;
  logic [LG-1:0]     root_idx;
  logic              res_valid_q, res_valid_d;
  logic [VAL_W-1:0]  res_value_q, res_value_d;
  logic [IDX_W-1:0]  res_run_q, res_run_d;
  logic              res_done_q, res_done_d;

  // An active item always has run < NR, so the narrowed index is exact.
  assign widx = item_i.run[LG-1:0];

  for (genvar g = 0; g < NR; g++) begin : g_run
    assign act[g] = (CNT_W'(g) < n_eff_i);
    assign heads_flat[g*VAL_W +: VAL_W] = head_q[g];
  end

  assign ready_all = &(hv_q | fin_q | ~act);

  kwm_min_tree #(
    .NR (NR)
  ) u_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .leaf_valid_i (hv_q & act),
    .leaf_value_i (heads_flat),
    .root_valid_o (root_valid),
    .root_value_o (root_value),
    .root_idx_o   (root_idx)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hv_d        = hv_q;
    fin_d       = fin_q;
    done_d      = done_q;
    pop_o       = 1'b0;
    wr_head     = 1'b0;
    res_valid_d = 1'b0;
    res_value_d = res_value_q;
    res_run_d   = res_run_q;
    res_done_d  = res_done_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (item_i.active && !fin_q[widx]) begin
            if (item_i.op == OP_PUSH) begin
              if (!hv_q[widx]) begin
                wr_head    = 1'b1;
                hv_d[widx] = 1'b1;
              end
            end else begin
              fin_d[widx] = 1'b1;
            end
          end
          state_d = ST_SEARCH;
          cnt_d   = '0;
        end
      end
      ST_SEARCH: begin
        if ((cnt_q == '0) && (done_q || !ready_all)) begin
          state_d = ST_IDLE;
        end else if (cnt_q == CW'(LG)) begin
          // The tree root has now settled on the heads left by the last update.
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (root_valid) begin
            res_value_d    = root_value;
            res_run_d      = IDX_W'(root_idx);
            res_done_d     = 1'b0;
            hv_d[root_idx] = 1'b0;
          end else begin
            res_value_d = '0;
            res_run_d   = '0;
            res_done_d  = 1'b1;
            done_d      = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hv_q        <= '0;
      fin_q       <= '0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hv_q        <= hv_d;
      fin_q       <= fin_d;
      done_q      <= done_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q <= res_value_d;
    res_run_q   <= res_run_d;
    res_done_q  <= res_done_d;
    if (wr_head) begin
      head_q[widx] <= item_i.value;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_value_o = res_value_q;
  assign res_run_o   = res_run_q;
  assign res_done_o  = res_done_q;

  // Each result returns the back end to idle, so results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("kwm_back: two results in consecutive cycles");

  // Once the final result has gone out, the stream stays closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !res_valid_q)
    else $error("kwm_back: result after end of merged stream");

  // The run named for refill no longer holds a head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_done_q) |-> !hv_q[res_run_q[LG-1:0]])
    else $error("kwm_back: refill run still holds its head");

  // The end-of-stream result carries no element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_done_q) |-> (res_value_q == '0 && res_run_q == '0 && done_q))
    else $error("kwm_back: malformed end-of-stream result");

endmodule

`default_nettype wire

// File: hw/rtl/k_way_run_merger.sv
// Top level of the k-way run merger: run count register, front queue and
// back end. Depends on kwm_pkg, kwm_front, kwm_back.
//
// Use: write the number of runs through the cfg channel (cfg_valid_i,
// cfg_data_i; cfg_ready_o is always high) while the block is idle. Then
// issue items with start; an item transfers at an edge where start is high
// and busy is low. Each item either supplies a run's next element (op 0) or
// reports the run exhausted (op 1). Once every active run holds a head or is
// finished, the block puts the smallest head on min_value_o with its run on
// refill_run_o for one cycle, marked by result_valid_o; the host then feeds
// that run again. After all runs drain, one result with merge_done_o set ends
// the stream.
// Timing: the back end handles one item at a time. An item that produces a
// result also waits for the registered min tree, which settles one level per
// cycle. With the back end idle, the strobe follows the item transfer through
// the front queue, the head update, the tree levels and the result register.
// A two-entry queue lets start be taken while the back end is busy. Reset
// clears all head-valid and finished flags and sets the run count to 1.
// The receiver cannot stall; every result must be taken in its cycle.
`timescale 1ns / 1ps
`default_nettype none

module k_way_run_merger
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CNT_W-1:0]        cfg_data_i,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    op_i,
  input  wire logic [IDX_W-1:0]        run_index_i,
  input  wire logic signed [VAL_W-1:0] element_value_i,
  output logic                         result_valid_o,
  output logic signed [VAL_W-1:0]      min_value_o,
  output logic [IDX_W-1:0]             refill_run_o,
  output logic                         merge_done_o
);

  // Runs beyond the reach of a run index can never be addressed.
  localparam int NR = (MAX_RUNS < IDX_RUNS) ? MAX_RUNS : IDX_RUNS;
  localparam logic [CNT_W-1:0] RunLimit = CNT_W'(NR);

  logic [CNT_W-1:0] run_count_q;
  logic [CNT_W-1:0] n_eff;
  logic             item_valid;
  kwm_item_t        item;
  logic             pop;
  logic [VAL_W-1:0] res_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      run_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (run_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (run_count_q > RunLimit) begin
      n_eff = RunLimit;
    end else begin
      n_eff = run_count_q;
    end
  end

  kwm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .run_index_i     (run_index_i),
    .element_value_i (element_value_i),
    .n_eff_i         (n_eff),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .pop_i           (pop)
  );

  kwm_back #(
    .NR (NR)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_eff_i      (n_eff),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .res_valid_o  (result_valid_o),
    .res_value_o  (res_value),
    .res_run_o    (refill_run_o),
    .res_done_o   (merge_done_o)
  );

  assign min_value_o = $signed(res_value);

endmodule

`default_nettype wire
